### rtl/ppwa_pkg.sv
// Shared types and constants for the page pool watermark allocator.
`timescale 1ns / 1ps
package ppwa_pkg;

  localparam int ROW_PAGES = 16;
  localparam int ROW_BITS  = 4;
  localparam int CMD_W     = 2;
  localparam int PAGE_W    = 8;
  localparam int COUNT_W   = 9;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_RESET = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_LIMITED   = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_ENABLE   = 2'd0,
    CFG_MAX_PAGES      = 2'd1,
    CFG_WATERMARK_HIGH = 2'd2,
    CFG_WATERMARK_LOW  = 2'd3
  } cfg_idx_t;

  // One row of the page maps: 16 pages, an in-use bit and a cached bit each.
  typedef struct packed {
    logic [ROW_PAGES-1:0] in_use;
    logic [ROW_PAGES-1:0] cached;
  } map_row_t;

endpackage

### rtl/ppwa_if.sv
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps
interface ppwa_req_if;
  logic                        valid;
  logic                        ready;
  logic [ppwa_pkg::CMD_W-1:0]  command;
  logic [ppwa_pkg::PAGE_W-1:0] page_index;
  modport source (output valid, command, page_index, input ready);
  modport sink (input valid, command, page_index, output ready);
endinterface

interface ppwa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ppwa_pkg::STATUS_W-1:0] status;
  logic [ppwa_pkg::PAGE_W-1:0]   granted_page;
  logic [ppwa_pkg::COUNT_W-1:0]  in_use_count;
  logic [ppwa_pkg::COUNT_W-1:0]  cached_count;
  logic [ppwa_pkg::COUNT_W-1:0]  released_count;
  modport source (output valid, status, granted_page, in_use_count, cached_count,
                  released_count, input ready);
  modport sink (input valid, status, granted_page, in_use_count, cached_count,
                released_count, output ready);
endinterface

interface ppwa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ppwa_pkg::CFG_IDX_W-1:0]  index;
  logic [ppwa_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/ppwa_map_mem.sv
// Page map row memory with per-row valid bits; an unwritten row reads as all clear.
`timescale 1ns / 1ps
module ppwa_map_mem #(
  parameter int ROWS = 16,
  parameter int RAW  = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clr,
  input  logic               rd_en,
  input  logic [RAW-1:0]     rd_addr,
  output ppwa_pkg::map_row_t rd_data,
  input  logic               wr_en,
  input  logic [RAW-1:0]     wr_addr,
  input  ppwa_pkg::map_row_t wr_data
);
  import ppwa_pkg::*;

  map_row_t  mem [ROWS];
  logic [ROWS-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

endmodule

### rtl/ppwa_prio.sv
// Shared 16-bit priority encoder, lowest-first or highest-first.
`timescale 1ns / 1ps
module ppwa_prio (
  input  logic [ppwa_pkg::ROW_PAGES-1:0] mask,
  input  logic                           high_first,
  output logic                           found,
  output logic [ppwa_pkg::ROW_BITS-1:0]  idx
);
  import ppwa_pkg::*;

  always_comb begin
    int j;
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < ROW_PAGES; i++) begin
      j = high_first ? i : (ROW_PAGES - 1 - i);
      if (mask[j]) begin
        found = 1'b1;
        idx   = ROW_BITS'(j);
      end
    end
  end

endmodule

### rtl/page_pool_watermark_allocator_top.sv
// Top level: page pool allocator with cache watermarks and its command sequencer.
`timescale 1ns / 1ps
// The pool's in-use and cached maps sit in a row memory of 16 pages per row,
// and one priority encoder walks it a row per cycle in an allocate scan, which
// starts at row 0 and moves up until a row offers a page. A free that lifts
// the cached count to watermark_high adds a release pass from the top row
// down; the pass stops once the cached count is no longer above watermark_low,
// or after row 0. Per-row valid bits clear the maps at once on a reset command,
// so no clearing pass runs after reset. One request is in work at a time; the
// response register lets the next request in while a response waits.
module page_pool_watermark_allocator_top #(
  parameter int POOL_PAGES = 256
) (
  input logic       clk,
  input logic       rst,
  ppwa_req_if.sink  req,
  ppwa_rsp_if.source rsp,
  ppwa_cfg_if.sink  cfg
);
  import ppwa_pkg::*;

  localparam int ROWS     = (POOL_PAGES + ROW_PAGES - 1) / ROW_PAGES;
  localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW       = $clog2(POOL_PAGES + 1);
  localparam int LAST_CNT = POOL_PAGES - (ROWS - 1) * ROW_PAGES;
  localparam logic [ROW_PAGES:0] LAST_MASK_W =
    ((ROW_PAGES + 1)'(1) << LAST_CNT) - (ROW_PAGES + 1)'(1);
  localparam logic [ROW_PAGES-1:0] LAST_MASK = LAST_MASK_W[ROW_PAGES-1:0];
  localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_CHK,
    S_FREE_CHK,
    S_REL_RD,
    S_REL_LD,
    S_REL_BIT,
    S_FINISH
  } state_t;

  state_t               state;
  logic                 want_cached;
  logic [RAW-1:0]       row;
  logic [ROW_BITS-1:0]  page_bit;
  map_row_t             row_buf;
  logic [CW-1:0]        in_use_total;
  logic [CW-1:0]        cached_total;
  status_t              res_status;
  logic [PAGE_W-1:0]    res_granted;
  logic [CW-1:0]        res_released;

  logic                 limit_enable;
  logic [COUNT_W-1:0]   max_pages;
  logic [COUNT_W-1:0]   watermark_high;
  logic [COUNT_W-1:0]   watermark_low;

  logic                 out_valid;
  status_t              out_status;
  logic [PAGE_W-1:0]    out_granted;
  logic [COUNT_W-1:0]   out_in_use;
  logic [COUNT_W-1:0]   out_cached;
  logic [COUNT_W-1:0]   out_released;

  // memory and encoder hookup
  logic                 mem_clr;
  logic                 rd_en;
  logic [RAW-1:0]       rd_addr;
  map_row_t             rd_row;
  logic                 wr_en;
  logic [RAW-1:0]       wr_addr;
  map_row_t             wr_data;
  logic [ROW_PAGES-1:0] enc_mask;
  logic                 enc_high;
  logic                 enc_found;
  logic [ROW_BITS-1:0]  enc_idx;

  logic [31:0]          page_wide;
  logic [RAW-1:0]       req_row;
  logic                 page_oob;
  logic                 accept;
  cmd_t                 cmd;
  logic [ROW_PAGES-1:0] row_mask;
  logic                 out_free;
  logic                 cached_above_low;
  logic                 limited;
  logic                 free_hit;
  logic [CW-1:0]        cached_inc;
  logic                 high_hit;

  ppwa_map_mem #(
    .ROWS (ROWS),
    .RAW  (RAW)
  ) u_map_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (mem_clr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ppwa_prio u_prio (
    .mask       (enc_mask),
    .high_first (enc_high),
    .found      (enc_found),
    .idx        (enc_idx)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign cmd       = cmd_t'(req.command);
  assign page_wide = 32'(req.page_index);
  assign req_row   = page_wide[ROW_BITS +: RAW];
  assign page_oob  = page_wide >= 32'(POOL_PAGES);
  assign row_mask  = (row == LAST_ROW) ? LAST_MASK : '1;
  assign out_free  = !out_valid || rsp.ready;
  assign cached_above_low = 32'(cached_total) > 32'(watermark_low);
  assign limited   = limit_enable && (32'(in_use_total) >= 32'(max_pages));
  assign free_hit  = rd_row.in_use[page_bit];
  assign cached_inc = cached_total + CW'(1);
  assign high_hit  = 32'(cached_inc) >= 32'(watermark_high);
  assign enc_high  = (state == S_REL_BIT);

  always_comb begin
    unique case (state)
      S_SCAN_CHK: enc_mask = want_cached ? rd_row.cached
                                         : (~(rd_row.in_use | rd_row.cached) & row_mask);
      S_REL_BIT:  enc_mask = row_buf.cached;
      default:    enc_mask = '0;
    endcase
  end

  always_comb begin
    mem_clr = 1'b0;
    rd_en   = 1'b0;
    rd_addr = row;
    wr_en   = 1'b0;
    wr_addr = row;
    wr_data = rd_row;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_ALLOC) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end else if (cmd == CMD_FREE && !page_oob) begin
            rd_en   = 1'b1;
            rd_addr = req_row;
          end else if (cmd == CMD_RESET) begin
            mem_clr = 1'b1;
          end
        end
      end
      S_SCAN_CHK: begin
        if (enc_found) begin
          wr_en = 1'b1;
          wr_data.in_use[enc_idx] = 1'b1;
          wr_data.cached[enc_idx] = 1'b0;
        end else if (row != LAST_ROW) begin
          rd_en   = 1'b1;
          rd_addr = row + RAW'(1);
        end
      end
      S_FREE_CHK: begin
        if (free_hit) begin
          wr_en = 1'b1;
          wr_data.in_use[page_bit] = 1'b0;
          wr_data.cached[page_bit] = 1'b1;
        end
      end
      S_REL_RD: begin
        rd_en = cached_above_low;
      end
      S_REL_BIT: begin
        if (!(enc_found && cached_above_low)) begin
          wr_en   = 1'b1;
          wr_data = row_buf;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      in_use_total   <= '0;
      cached_total   <= '0;
      limit_enable   <= 1'b0;
      max_pages      <= COUNT_W'(256);
      watermark_high <= COUNT_W'(256);
      watermark_low  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg_idx_t'(cfg.index))
          CFG_LIMIT_ENABLE:   limit_enable   <= cfg.data[0];
          CFG_MAX_PAGES:      max_pages      <= cfg.data;
          CFG_WATERMARK_HIGH: watermark_high <= cfg.data;
          CFG_WATERMARK_LOW:  watermark_low  <= cfg.data;
        endcase
      end

      if (out_valid && rsp.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_granted  <= '0;
            res_released <= '0;
            page_bit     <= page_wide[ROW_BITS-1:0];
            if (cmd == CMD_ALLOC) begin
              want_cached <= (cached_total != '0);
              row         <= '0;
              if (cached_total == '0 && limited) begin
                res_status <= ST_LIMITED;
                state      <= S_FINISH;
              end else begin
                res_status <= ST_OK;
                state      <= S_SCAN_CHK;
              end
            end else if (cmd == CMD_FREE) begin
              row <= req_row;
              if (page_oob) begin
                res_status <= ST_UNKNOWN;
                state      <= S_FINISH;
              end else begin
                res_status <= ST_OK;
                state      <= S_FREE_CHK;
              end
            end else if (cmd == CMD_RESET) begin
              res_status   <= ST_OK;
              in_use_total <= '0;
              cached_total <= '0;
              state        <= S_FINISH;
            end else begin
              res_status <= ST_OK;
              state      <= S_FINISH;
            end
          end
        end
        S_SCAN_CHK: begin
          if (enc_found) begin
            in_use_total <= in_use_total + CW'(1);
            if (want_cached) begin
              cached_total <= cached_total - CW'(1);
            end
            res_granted <= PAGE_W'({row, enc_idx});
            state       <= S_FINISH;
          end else if (row == LAST_ROW) begin
            res_status <= ST_EXHAUSTED;
            state      <= S_FINISH;
          end else begin
            row <= row + RAW'(1);
          end
        end
        S_FREE_CHK: begin
          if (free_hit) begin
            in_use_total <= in_use_total - CW'(1);
            cached_total <= cached_inc;
            if (high_hit) begin
              row   <= LAST_ROW;
              state <= S_REL_RD;
            end else begin
              state <= S_FINISH;
            end
          end else begin
            res_status <= ST_UNKNOWN;
            state      <= S_FINISH;
          end
        end
        S_REL_RD: begin
          state <= cached_above_low ? S_REL_LD : S_FINISH;
        end
        S_REL_LD: begin
          row_buf <= rd_row;
          state   <= S_REL_BIT;
        end
        S_REL_BIT: begin
          if (enc_found && cached_above_low) begin
            row_buf.cached[enc_idx] <= 1'b0;
            cached_total <= cached_total - CW'(1);
            res_released <= res_released + CW'(1);
          end else if (!cached_above_low || row == '0) begin
            state <= S_FINISH;
          end else begin
            row   <= row - RAW'(1);
            state <= S_REL_RD;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_status   <= res_status;
            out_granted  <= res_granted;
            out_in_use   <= COUNT_W'(in_use_total);
            out_cached   <= COUNT_W'(cached_total);
            out_released <= COUNT_W'(res_released);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.granted_page   = out_granted;
  assign rsp.in_use_count   = out_in_use;
  assign rsp.cached_count   = out_cached;
  assign rsp.released_count = out_released;

`ifndef SYNTHESIS
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(in_use_total) + 32'(cached_total)) <= 32'(POOL_PAGES))
    else $error("page counts exceed pool size");

  a_no_rw_same_row: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en && rd_addr == wr_addr))
    else $error("map row read and written in the same cycle");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished request not moved to response register");

  a_release_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_released == '0))
    else $error("release count on a failed request");
`endif

endmodule

### sim/page_pool_watermark_allocator_top_tb.sv
// Self-checking testbench for the page pool watermark allocator top level.
`timescale 1ns / 1ps
module page_pool_watermark_allocator_top_tb;
  import ppwa_pkg::*;

  localparam int POOL_PAGES     = 256;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 40;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 115;
  localparam int MAX_REPORTS    = 60;

  typedef struct packed {
    status_t             st;
    logic [PAGE_W-1:0]   page;
    logic [COUNT_W-1:0]  in_use;
    logic [COUNT_W-1:0]  cached;
    logic [COUNT_W-1:0]  released;
  } rsp_t;

  typedef struct packed {
    bit                    is_cfg;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [CMD_W-1:0]      cmd;
    logic [PAGE_W-1:0]     page;
    bit                    typed;
    rsp_t                  exp;
  } step_t;

  logic clk = 1'b0;
  logic rst;

  ppwa_req_if req ();
  ppwa_rsp_if rsp ();
  ppwa_cfg_if cfg ();

  page_pool_watermark_allocator_top #(.POOL_PAGES(POOL_PAGES)) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always #5 clk = ~clk;

  // Shadow pool state and registers
  bit [POOL_PAGES-1:0] busy_map;
  bit [POOL_PAGES-1:0] cache_map;
  int                  busy_total;
  int                  cache_total;
  bit                  lim_en;
  int                  lim_max;
  int                  wm_hi;
  int                  wm_lo;

  rsp_t results_due[$];
  rsp_t got_want;
  int   errors;
  int   status_hits[4];
  int   release_runs;
  int   req_count;
  int   cfg_writes;
  bit   idle_on;
  int   stall_left;

  function automatic int lowest_set(bit [POOL_PAGES-1:0] m);
    int f;
    f = -1;
    for (int i = POOL_PAGES - 1; i >= 0; i--)
      if (m[i]) f = i;
    return f;
  endfunction

  function automatic void pool_clear();
    busy_map    = '0;
    cache_map   = '0;
    busy_total  = 0;
    cache_total = 0;
  endfunction

  function automatic rsp_t pool_step(logic [CMD_W-1:0] c, logic [PAGE_W-1:0] pg);
    rsp_t r;
    int   p;
    int   rel;
    r   = '0;
    rel = 0;
    case (c)
      CMD_ALLOC: begin
        p = lowest_set(cache_map);
        if (p >= 0) begin
          cache_map[p] = 1'b0;
          cache_total--;
        end else if (lim_en && busy_total >= lim_max) begin
          r.st = ST_LIMITED;
        end else begin
          p = lowest_set(~(busy_map | cache_map));
          if (p < 0) r.st = ST_EXHAUSTED;
        end
        if (r.st == ST_OK && p >= 0) begin
          busy_map[p] = 1'b1;
          busy_total++;
          r.page = p[PAGE_W-1:0];
        end
      end
      CMD_FREE: begin
        if (!busy_map[pg]) begin
          r.st = ST_UNKNOWN;
        end else begin
          busy_map[pg]  = 1'b0;
          busy_total--;
          cache_map[pg] = 1'b1;
          cache_total++;
          if (cache_total >= wm_hi)
            for (int i = POOL_PAGES - 1; i >= 0; i--)
              if (cache_total > wm_lo && cache_map[i]) begin
                cache_map[i] = 1'b0;
                cache_total--;
                rel++;
              end
        end
      end
      CMD_RESET: pool_clear();
      default: ;
    endcase
    r.in_use   = busy_total[COUNT_W-1:0];
    r.cached   = cache_total[COUNT_W-1:0];
    r.released = rel[COUNT_W-1:0];
    return r;
  endfunction

  // Random page currently in use, or -1
  function automatic int pick_in_use();
    int start;
    int f;
    start = $urandom_range(0, POOL_PAGES - 1);
    f = -1;
    for (int k = POOL_PAGES - 1; k >= 0; k--)
      if (busy_map[(start + k) % POOL_PAGES]) f = (start + k) % POOL_PAGES;
    return f;
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 256;
      2: return $urandom_range(1, 32);
      default: return $urandom_range(0, 256);
    endcase
  endfunction

  function automatic step_t do_req(logic [CMD_W-1:0] c, logic [PAGE_W-1:0] p);
    step_t s;
    s = '0;
    s.cmd = c;
    s.page = p;
    return s;
  endfunction

  function automatic step_t do_chk(logic [CMD_W-1:0] c, logic [PAGE_W-1:0] p, status_t st,
                                   int pg, int iu, int ca, int rel);
    step_t s;
    s = do_req(c, p);
    s.typed = 1'b1;
    s.exp.st = st;
    s.exp.page = pg[PAGE_W-1:0];
    s.exp.in_use = iu[COUNT_W-1:0];
    s.exp.cached = ca[COUNT_W-1:0];
    s.exp.released = rel[COUNT_W-1:0];
    return s;
  endfunction

  function automatic step_t do_cfg(cfg_idx_t i, int d);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = i;
    s.data = d[CFG_DATA_W-1:0];
    return s;
  endfunction

  function automatic void note(string what, int e, int a);
    if (e != a) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, e, a);
    end
  endfunction

  // Hold off new requests until every outstanding response is back
  task automatic settle();
    if (req.valid) req.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_req(input logic [CMD_W-1:0] c, input logic [PAGE_W-1:0] p,
                          input bit typed, input rsp_t fixed);
    rsp_t want;
    if (cfg.valid) cfg.valid <= 1'b0;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.command    <= c;
    req.page_index <= p;
    do @(posedge clk); while (!req.ready);
    want = pool_step(c, p);
    status_hits[want.st]++;
    if (want.released != 0) release_runs++;
    req_count++;
    if (typed) want = fixed;
    results_due.push_back(want);
  endtask

  task automatic write_reg(input cfg_idx_t i, input logic [CFG_DATA_W-1:0] d);
    settle();
    cfg.valid <= 1'b1;
    cfg.index <= i;
    cfg.data  <= d;
    do @(posedge clk); while (!cfg.ready);
    case (i)
      CFG_LIMIT_ENABLE:   lim_en  = d[0];
      CFG_MAX_PAGES:      lim_max = int'(d);
      CFG_WATERMARK_HIGH: wm_hi   = int'(d);
      CFG_WATERMARK_LOW:  wm_lo   = int'(d);
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Response side: random back-pressure and checking
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: response with no request outstanding, expected none, got status %0d",
                   $time, rsp.status);
        end else begin
          got_want = results_due.pop_front();
          note("status", int'(got_want.st), int'(rsp.status));
          note("granted_page", int'(got_want.page), int'(rsp.granted_page));
          note("in_use_count", int'(got_want.in_use), int'(rsp.in_use_count));
          note("cached_count", int'(got_want.cached), int'(rsp.cached_count));
          note("released_count", int'(got_want.released), int'(rsp.released_count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("page_pool_watermark_allocator_top_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    step_t               plan[$];
    rsp_t                none;
    int                  w;
    int                  r;
    int                  pick;
    int                  en;
    int                  mx;
    int                  hi;
    int                  lo;
    logic [CFG_DATA_W-1:0] d;
    logic [CMD_W-1:0]    c;
    logic [PAGE_W-1:0]   pg;

    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.command    <= CMD_ALLOC;
    req.page_index <= '0;
    cfg.valid      <= 1'b0;
    cfg.index      <= CFG_LIMIT_ENABLE;
    cfg.data       <= '0;
    none = '0;
    errors = 0;
    release_runs = 0;
    req_count = 0;
    cfg_writes = 0;
    foreach (status_hits[k]) status_hits[k] = 0;
    idle_on = 1'b1;
    pool_clear();
    lim_en  = 1'b0;
    lim_max = 256;
    wm_hi   = 256;
    wm_lo   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset state
    plan.push_back(do_chk(CMD_ALLOC, 8'h00, ST_OK, 0, 1, 0, 0));
    plan.push_back(do_chk(CMD_ALLOC, 8'hFF, ST_OK, 1, 2, 0, 0));
    plan.push_back(do_chk(CMD_FREE, 8'hFF, ST_UNKNOWN, 0, 2, 0, 0));
    plan.push_back(do_req(CMD_FREE, 8'h01));
    plan.push_back(do_chk(CMD_FREE, 8'h01, ST_UNKNOWN, 0, 1, 1, 0));
    plan.push_back(do_req(CMD_ALLOC, 8'h55));
    plan.push_back(do_req(2'd3, 8'hAA));
    plan.push_back(do_chk(CMD_RESET, 8'h00, ST_OK, 0, 0, 0, 0));
    plan.push_back(do_chk(CMD_FREE, 8'h00, ST_UNKNOWN, 0, 0, 0, 0));
    plan.push_back(do_cfg(CFG_LIMIT_ENABLE, 1));
    plan.push_back(do_cfg(CFG_MAX_PAGES, 0));
    plan.push_back(do_chk(CMD_ALLOC, 8'h00, ST_LIMITED, 0, 0, 0, 0));
    plan.push_back(do_cfg(CFG_MAX_PAGES, 2));
    plan.push_back(do_req(CMD_ALLOC, 8'h00));
    plan.push_back(do_req(CMD_ALLOC, 8'h00));
    plan.push_back(do_chk(CMD_ALLOC, 8'h00, ST_LIMITED, 0, 2, 0, 0));
    plan.push_back(do_req(CMD_FREE, 8'h00));
    plan.push_back(do_cfg(CFG_MAX_PAGES, 1));
    plan.push_back(do_req(CMD_ALLOC, 8'h00));   // cache wins over the limit
    plan.push_back(do_cfg(CFG_WATERMARK_HIGH, 1));
    plan.push_back(do_req(CMD_FREE, 8'h01));
    plan.push_back(do_cfg(CFG_WATERMARK_LOW, 256));
    plan.push_back(do_req(CMD_FREE, 8'h00));    // low mark above high: no release
    plan.push_back(do_chk(CMD_RESET, 8'hFF, ST_OK, 0, 0, 0, 0));
    plan.push_back(do_cfg(CFG_LIMIT_ENABLE, 0));
    plan.push_back(do_cfg(CFG_MAX_PAGES, 256));
    plan.push_back(do_cfg(CFG_WATERMARK_HIGH, 256));
    plan.push_back(do_cfg(CFG_WATERMARK_LOW, 0));
    foreach (plan[k]) begin
      if (plan[k].is_cfg)
        write_reg(plan[k].idx, plan[k].data);
      else
        send_req(plan[k].cmd, plan[k].page, plan[k].typed, plan[k].exp);
    end

    // Fill the whole pool past exhaustion, then free every page back
    send_req(CMD_RESET, PAGE_W'($urandom_range(0, 255)), 1'b0, none);
    repeat (POOL_PAGES + 4) send_req(CMD_ALLOC, PAGE_W'($urandom_range(0, 255)), 1'b0, none);
    pick = pick_in_use();
    while (pick >= 0) begin
      send_req(CMD_FREE, pick[PAGE_W-1:0], 1'b0, none);
      pick = pick_in_use();
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin en = 1; mx = 256; hi = 0; lo = 0; end
        1: begin
          en = 1;
          mx = $urandom_range(1, 40);
          hi = $urandom_range(2, 16);
          lo = $urandom_range(0, hi - 1);
        end
        2: begin en = 0; mx = 0; hi = 256; lo = 256; end
        3: begin en = 1; mx = 0; hi = $urandom_range(1, 24); lo = $urandom_range(0, hi); end
        default: begin
          en = $urandom_range(0, 1);
          mx = pick_size();
          hi = pick_size();
          lo = ($urandom_range(0, 1) == 0) ? pick_size() : $urandom_range(0, hi);
        end
      endcase
      d = CFG_DATA_W'($urandom_range(0, 511));
      d[0] = en[0];
      write_reg(CFG_LIMIT_ENABLE, d);
      write_reg(CFG_MAX_PAGES, mx[CFG_DATA_W-1:0]);
      write_reg(CFG_WATERMARK_HIGH, hi[CFG_DATA_W-1:0]);
      write_reg(CFG_WATERMARK_LOW, lo[CFG_DATA_W-1:0]);
      if (ph == PHASES - 1) idle_on = 1'b0;
      w = $urandom_range(35, 70);
      repeat (PHASE_ITEMS) begin
        r  = $urandom_range(0, 99);
        pg = PAGE_W'($urandom_range(0, 255));
        if (r < w) begin
          c = CMD_ALLOC;
        end else if (r < 95) begin
          c = CMD_FREE;
          pick = pick_in_use();
          if (pick >= 0 && $urandom_range(0, 4) != 0) pg = pick[PAGE_W-1:0];
        end else if (r < 97) begin
          c = 2'd3;
        end else begin
          c = CMD_RESET;
        end
        send_req(c, pg, 1'b0, none);
        if (idle_on && $urandom_range(0, 99) == 0) settle();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests, %0d register writes, %0d release passes", req_count, cfg_writes,
             release_runs);
    $display("status ok %0d, limited %0d, unknown page %0d, exhausted %0d",
             status_hits[ST_OK], status_hits[ST_LIMITED], status_hits[ST_UNKNOWN],
             status_hits[ST_EXHAUSTED]);
    if (errors == 0 && results_due.size() == 0) begin
      $display("page_pool_watermark_allocator_top_tb: done, clean");
    end else begin
      $display("page_pool_watermark_allocator_top_tb: done, errors");
    end
    $finish;
  end

endmodule
